### rtl/lru_key_value_cache_core_assert.svh
// Assertion macros for the LRU key-value cache core
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LKV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkv check failed: ante |-> cons");

`define LKV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkv check failed: ante |=> cons");

`else

`define LKV_ASSERT_IMP(label, ante, cons)

`define LKV_ASSERT_NXT(label, ante, cons)

`endif

`endif

### rtl/lkv_pkg.sv
package lkv_pkg;

    localparam int CAP       = 16;
    localparam int IDX_W     = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int AGE_W     = IDX_W;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int CAP_RESET = 16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [AGE_W-1:0]  age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } result_t;

endpackage

### rtl/lkv_ram.sv
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/lkv_engine.sv
module lkv_engine import lkv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op_func,
    input  logic [DATA_W-1:0] op_key,
    input  logic [DATA_W-1:0] op_value,
    input  logic [CFG_W-1:0]  capacity,
    input  logic              out_free,
    output logic              ready,
    output logic              done,
    output result_t           res,
    output logic [IDX_W-1:0]  ram_raddr,
    input  entry_t            ram_rdata,
    output logic              ram_we,
    output logic [IDX_W-1:0]  ram_waddr,
    output entry_t            ram_wdata
);

    state_t              state_reg, state_next;
    logic                func_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [CAP-1:0]      valid_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                pv_reg;
    logic [IDX_W-1:0]    pi_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [AGE_W-1:0]    hit_age_reg;
    logic [DATA_W-1:0]   hit_val_reg;
    logic                any_reg;
    logic [AGE_W-1:0]    best_age_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [DATA_W-1:0]   best_key_reg;
    logic [IDX_W-1:0]    tgt_idx_reg;
    logic                ins_reg;
    logic                inc_all_reg;
    logic [AGE_W-1:0]    ref_age_reg;
    result_t             res_reg;

    logic                issue;
    logic                last;
    logic                is_put;
    logic                rvalid;
    logic                key_match;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    eff_cap;
    logic                need_evict;
    logic                ins;
    logic                evict;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    tgt_idx;

    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                       && (rd_cnt_reg < CNT_W'(CAP));
    assign last      = pv_reg && (pi_reg == IDX_W'(CAP - 1));
    assign is_put    = (func_reg == FUNC_PUT);
    assign rvalid    = valid_reg[pi_reg];
    assign key_match = rvalid && (ram_rdata.key == key_reg);
    assign ram_raddr = rd_cnt_reg[IDX_W-1:0];

    assign cap_ext    = CMP_W'(capacity);
    assign eff_cap    = (cap_ext == '0) ? CMP_W'(1)
                      : ((cap_ext > CMP_W'(CAP)) ? CMP_W'(CAP) : cap_ext);
    assign need_evict = (CMP_W'(count_reg) >= eff_cap);
    assign ins        = is_put && !hit_reg;
    assign evict      = ins && need_evict && any_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign tgt_idx = hit_reg ? hit_idx_reg
                   : ((ins && need_evict) ? best_idx_reg : free_idx);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (!is_put && !hit_reg) ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ready = (state_reg == ST_IDLE);
    assign done  = (state_reg == ST_DONE) && out_free;
    assign res   = res_reg;

    always_comb
    begin
        ram_we    = (state_reg == ST_UPDATE) && pv_reg;
        ram_waddr = pi_reg;
        ram_wdata = ram_rdata;
        if (pi_reg == tgt_idx_reg)
        begin
            ram_wdata.key   = ins_reg ? key_reg : ram_rdata.key;
            ram_wdata.value = is_put ? value_reg : ram_rdata.value;
            ram_wdata.age   = '0;
        end
        else if (rvalid && (inc_all_reg || (ram_rdata.age < ref_age_reg)))
        begin
            ram_wdata.age = ram_rdata.age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            pv_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            any_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= issue;
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (start && ready)
            begin
                rd_cnt_reg <= '0;
                hit_reg    <= 1'b0;
                any_reg    <= 1'b0;
            end
            if ((state_reg == ST_SCAN) && pv_reg)
            begin
                if (key_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (rvalid && (!any_reg || (ram_rdata.age > best_age_reg)))
                begin
                    any_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                rd_cnt_reg <= '0;
                if (ins)
                begin
                    valid_reg[tgt_idx] <= 1'b1;
                    if (!evict)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && ready)
        begin
            func_reg     <= op_func;
            key_reg      <= op_key;
            value_reg    <= op_value;
            best_idx_reg <= '0;
        end
        pi_reg <= ram_raddr;
        if ((state_reg == ST_SCAN) && pv_reg)
        begin
            if (key_match && !hit_reg)
            begin
                hit_idx_reg <= pi_reg;
                hit_age_reg <= ram_rdata.age;
                hit_val_reg <= ram_rdata.value;
            end
            if (rvalid && (!any_reg || (ram_rdata.age > best_age_reg)))
            begin
                best_age_reg <= ram_rdata.age;
                best_idx_reg <= pi_reg;
                best_key_reg <= ram_rdata.key;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            tgt_idx_reg             <= tgt_idx;
            ins_reg                 <= ins;
            inc_all_reg             <= ins;
            ref_age_reg             <= hit_age_reg;
            res_reg.hit             <= hit_reg;
            res_reg.read_value      <= (!is_put && hit_reg) ? hit_val_reg : '0;
            res_reg.evicted         <= evict;
            res_reg.evicted_key     <= evict ? best_key_reg : '0;
        end
    end

endmodule

### rtl/lru_key_value_cache_core.sv
// LRU key-value cache core, fully associative, CAP entries in one entry RAM.
// Each request makes a scan pass over all entries, a decide step and an update
// pass that rewrites every entry; a get that misses skips the update pass.
// A new request is taken only when the engine is idle, so requests do not overlap;
// a finished result held off by out_ready also stalls the engine. One RAM read port.
// Reset: rst_n clears valid bits, entry count and handshake state; capacity is 16.
`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core import lkv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [DATA_W-1:0] read_value,
    output logic              evicted,
    output logic [DATA_W-1:0] evicted_key,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [CFG_W-1:0]  capacity_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              eng_ready;
    logic              eng_done;
    result_t           eng_res;
    logic              out_free;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_we;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    assign out_free = !out_valid_reg || out_ready;

    lkv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAP),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lkv_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid),
        .op_func   (func),
        .op_key    (key),
        .op_value  (value),
        .capacity  (capacity_reg),
        .out_free  (out_free),
        .ready     (eng_ready),
        .done      (eng_done),
        .res       (eng_res),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    assign in_ready = eng_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CFG_W'(CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (eng_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the transfer
    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_reg <= eng_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_reg.hit;
    assign read_value  = out_reg.read_value;
    assign evicted     = out_reg.evicted;
    assign evicted_key = out_reg.evicted_key;

    `LKV_ASSERT_IMP(a_evict_only_on_miss, out_valid && evicted, !hit)
    `LKV_ASSERT_IMP(a_read_value_needs_hit, out_valid && (read_value != '0), hit)
    `LKV_ASSERT_IMP(a_evicted_key_needs_evict, out_valid && (evicted_key != '0), evicted)
    `LKV_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

endmodule
